// ===== src/fan_rpm_lag_slew_filter_core_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef FAN_RPM_LAG_SLEW_FILTER_CORE_MACROS_SVH
`define FAN_RPM_LAG_SLEW_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRLSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRLSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/frlsf_pkg.sv =====
`timescale 1ns / 1ps
package frlsf_pkg;

   // One reading for one fan.
   typedef struct packed {
      logic [1:0]  fan_index;
      logic [31:0] now_ms;
      logic [15:0] raw_count;
      logic        read_ok;
   } req_type;

   // One filtered result.
   typedef struct packed {
      logic [15:0] rpm;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] STATUS_UPDATED = 2'd0;
   localparam logic [1:0] STATUS_HELD    = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   localparam logic [2:0] REG_MAX_RPM      = 3'd0;
   localparam logic [2:0] REG_TAU_MS       = 3'd1;
   localparam logic [2:0] REG_SLEW         = 3'd2;
   localparam logic [2:0] REG_STOP_THR     = 3'd3;
   localparam logic [2:0] REG_STEP_COUNT   = 3'd4;
   localparam logic [2:0] REG_MULTIPLIER   = 3'd5;
   localparam logic [2:0] REG_MIN_INTERVAL = 3'd6;
   localparam logic [2:0] REG_RESET_GAP    = 3'd7;

   localparam logic [15:0] RST_MAX_RPM      = 16'd5000;
   localparam logic [15:0] RST_TAU_MS       = 16'd1000;
   localparam logic [15:0] RST_SLEW         = 16'd1250;
   localparam logic [15:0] RST_STOP_THR     = 16'd50;
   localparam logic [15:0] RST_STEP_COUNT   = 16'd0;
   localparam logic [7:0]  RST_MULTIPLIER   = 8'd1;
   localparam logic [15:0] RST_MIN_INTERVAL = 16'd100;
   localparam logic [15:0] RST_RESET_GAP    = 16'd5000;

   localparam logic [15:0] STOP_FLOOR  = 16'd10;
   localparam logic [16:0] MS_PER_SEC  = 17'd1000;

   localparam int DIV_DW = 32;
   localparam int DIV_SW = 17;
   localparam int DIV_CW = $clog2(DIV_DW);

   // Command into the shared divider.
   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_SW-1:0] divisor;
   } div_req_type;

   // Result from the shared divider; quotient is valid while done is high.
   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/frlsf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module frlsf_div
   import frlsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_SW-1:0] dvs_ff, dvs_in;
   logic [DIV_SW:0]   trial;
   logic [DIV_SW:0]   diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_DW-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = busy_ff && (cnt_ff == '0);
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(DIV_DW - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_DW-2:0], ge};
         rem_in = ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== src/fan_rpm_lag_slew_filter_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_type: fan_index, now_ms, raw_count, read_ok
// rsp       out        rsp_valid/stall    rsp_type: rpm, status
// csr       in/out     APB psel/penable   eight registers at byte address 4*i, 16-bit except the 8-bit multiplier
//
// A request for an unknown fan, a held reading or a read error goes from the check state straight to done.
// A full filter update makes up to three passes through the shared divider (count scaling,
// lag coefficient, slew limit), with the sequencer's multiply and decide steps between them.
// Synchronous reset clears the registers to their defaults and every fan's state to zero.
// A request is taken only while the sequencer is idle; a waiting result does not block
// new requests, but a finished request waits for the output register to drain.
`include "fan_rpm_lag_slew_filter_core_macros.svh"
module fan_rpm_lag_slew_filter_core
   import frlsf_pkg::*;
#(
   parameter int FAN_COUNT       = 3,
   parameter int ALPHA_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int FAN_IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
   localparam int PROD_W    = 34;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHECK     = 4'd1;
   localparam logic [3:0] ST_MUL_RPM   = 4'd2;
   localparam logic [3:0] ST_DIV_RPM   = 4'd3;
   localparam logic [3:0] ST_DECIDE    = 4'd4;
   localparam logic [3:0] ST_DIV_ALPHA = 4'd5;
   localparam logic [3:0] ST_MUL_STEP  = 4'd6;
   localparam logic [3:0] ST_MUL_SLEW  = 4'd7;
   localparam logic [3:0] ST_LIM_START = 4'd8;
   localparam logic [3:0] ST_DIV_LIM   = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   // Configuration registers.
   logic [15:0] max_rpm_ff, tau_ff, slew_ff, stop_ff, steps_ff;
   logic [7:0]  mult_ff;
   logic [15:0] min_int_ff, gap_ff;
   logic        csr_wr;

   // Per-fan state.
   logic [15:0] speed_mem_ff [FAN_COUNT];
   logic [31:0] time_mem_ff  [FAN_COUNT];
   logic [FAN_COUNT-1:0] seen_mem_ff;

   // Sequencer and working registers.
   logic [3:0]  state_ff, state_in;
   logic [1:0]  fan_ff, fan_in;
   logic        fan_ok_ff, fan_ok_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] raw_ff, raw_in;
   logic        ok_ff, ok_in;
   logic [15:0] cur_speed_ff, cur_speed_in;
   logic [31:0] cur_time_ff, cur_time_in;
   logic        cur_seen_ff, cur_seen_in;
   logic [31:0] dt_ff, dt_in;
   logic [15:0] reading_ff, reading_in;
   logic        neg_ff, neg_in;
   logic [15:0] dmag_ff, dmag_in;
   logic [16:0] alpha_ff, alpha_in;
   logic [15:0] step_ff, step_in;
   logic [15:0] new_ff, new_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        upd_ff, upd_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [FAN_IDX_W-1:0] rd_idx, wr_idx;
   logic        req_take, req_in_range, state_wr, out_free;
   logic [16:0] mul_a, mul_b;
   logic [15:0] thr, dt16, clamp_rpm, lim16;
   logic [16:0] den;
   logic [PROD_W:0]   rounded;
   logic [PROD_W:0]   shifted;
   logic [DIV_DW-1:0] lim;
   div_req_type div_req;
   div_rsp_type div_rsp;

   frlsf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Register file. pready is tied high, so a write lands in the access cycle.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[4:2])
         REG_MAX_RPM:      prdata = 32'(max_rpm_ff);
         REG_TAU_MS:       prdata = 32'(tau_ff);
         REG_SLEW:         prdata = 32'(slew_ff);
         REG_STOP_THR:     prdata = 32'(stop_ff);
         REG_STEP_COUNT:   prdata = 32'(steps_ff);
         REG_MULTIPLIER:   prdata = 32'(mult_ff);
         REG_MIN_INTERVAL: prdata = 32'(min_int_ff);
         REG_RESET_GAP:    prdata = 32'(gap_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rpm_ff <= RST_MAX_RPM;
         tau_ff     <= RST_TAU_MS;
         slew_ff    <= RST_SLEW;
         stop_ff    <= RST_STOP_THR;
         steps_ff   <= RST_STEP_COUNT;
         mult_ff    <= RST_MULTIPLIER;
         min_int_ff <= RST_MIN_INTERVAL;
         gap_ff     <= RST_RESET_GAP;
      end else if (csr_wr) begin
         unique case (paddr[4:2])
            REG_MAX_RPM:      max_rpm_ff <= pwdata[15:0];
            REG_TAU_MS:       tau_ff     <= pwdata[15:0];
            REG_SLEW:         slew_ff    <= pwdata[15:0];
            REG_STOP_THR:     stop_ff    <= pwdata[15:0];
            REG_STEP_COUNT:   steps_ff   <= pwdata[15:0];
            REG_MULTIPLIER:   mult_ff    <= pwdata[7:0];
            REG_MIN_INTERVAL: min_int_ff <= pwdata[15:0];
            REG_RESET_GAP:    gap_ff     <= pwdata[15:0];
            default:          ;
         endcase
      end
   end

   // Handshake. A new request is taken only while the sequencer idles.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign state_wr  = (state_ff == ST_DONE) && out_free && upd_ff;

   assign rd_idx       = FAN_IDX_W'(req_data.fan_index);
   assign wr_idx       = FAN_IDX_W'(fan_ff);
   assign req_in_range = 32'(req_data.fan_index) < FAN_COUNT;

   // The lag path is only reached when dt does not exceed the 16-bit snap gap.
   assign dt16 = dt_ff[15:0];
   assign thr  = (stop_ff > STOP_FLOOR) ? stop_ff : STOP_FLOOR;
   assign den  = {1'b0, tau_ff} + {1'b0, dt16};

   // The shared multiplier: operands are chosen by state, the product is
   // registered and used in the following state.
   always_comb begin
      unique case (state_ff)
         ST_CHECK: begin
            mul_a = {1'b0, raw_ff};
            mul_b = (steps_ff != '0) ? {1'b0, max_rpm_ff} : 17'(mult_ff);
         end
         ST_MUL_STEP: begin
            mul_a = {1'b0, dmag_ff};
            mul_b = alpha_ff;
         end
         ST_MUL_SLEW: begin
            mul_a = {1'b0, slew_ff};
            mul_b = {1'b0, dt16};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // Clamp of a scaled reading to the maximum speed.
   always_comb begin
      if (steps_ff != '0) begin
         clamp_rpm = (div_rsp.quotient > 32'(max_rpm_ff)) ? max_rpm_ff
                                                          : div_rsp.quotient[15:0];
      end else begin
         clamp_rpm = (prod_ff > PROD_W'(max_rpm_ff)) ? max_rpm_ff : prod_ff[15:0];
      end
   end

   // Lag step magnitude. A decreasing step rounds its magnitude up, which is
   // the same as flooring the signed step.
   always_comb begin
      rounded = {1'b0, prod_ff} + (neg_ff ? ((PROD_W+1)'(1) << ALPHA_FRAC_BITS)
                                            - (PROD_W+1)'(1)
                                          : '0);
      shifted = rounded >> ALPHA_FRAC_BITS;
   end

   // Slew limit, never below one.
   assign lim   = (div_rsp.quotient == '0) ? DIV_DW'(1) : div_rsp.quotient;
   assign lim16 = lim[15:0];

   always_comb begin
      state_in      = state_ff;
      fan_in        = fan_ff;
      fan_ok_in     = fan_ok_ff;
      now_in        = now_ff;
      raw_in        = raw_ff;
      ok_in         = ok_ff;
      cur_speed_in  = cur_speed_ff;
      cur_time_in   = cur_time_ff;
      cur_seen_in   = cur_seen_ff;
      dt_in         = dt_ff;
      reading_in    = reading_ff;
      neg_in        = neg_ff;
      dmag_in       = dmag_ff;
      alpha_in      = alpha_ff;
      step_in       = step_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      upd_in        = upd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      div_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               fan_in    = req_data.fan_index;
               fan_ok_in = req_in_range;
               now_in    = req_data.now_ms;
               raw_in    = req_data.raw_count;
               ok_in     = req_data.read_ok;
               if (req_in_range) begin
                  cur_speed_in = speed_mem_ff[rd_idx];
                  cur_time_in  = time_mem_ff[rd_idx];
                  cur_seen_in  = seen_mem_ff[rd_idx];
               end else begin
                  cur_speed_in = '0;
                  cur_time_in  = '0;
                  cur_seen_in  = 1'b0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Early exits come first, in the order the rules are checked.
            dt_in  = now_ff - cur_time_ff;
            upd_in = 1'b0;
            if (!fan_ok_ff) begin
               new_in        = '0;
               res_status_in = STATUS_ERROR;
               state_in      = ST_DONE;
            end else if (cur_seen_ff && (dt_in < 32'(min_int_ff))) begin
               new_in        = cur_speed_ff;
               res_status_in = STATUS_HELD;
               state_in      = ST_DONE;
            end else if (!ok_ff) begin
               new_in        = cur_speed_ff;
               res_status_in = STATUS_ERROR;
               state_in      = ST_DONE;
            end else begin
               res_status_in = STATUS_UPDATED;
               state_in      = ST_MUL_RPM;
            end
         end
         ST_MUL_RPM: begin
            if (steps_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = prod_ff[DIV_DW-1:0];
               div_req.divisor  = {1'b0, steps_ff};
               state_in         = ST_DIV_RPM;
            end else begin
               reading_in = clamp_rpm;
               state_in   = ST_DECIDE;
            end
         end
         ST_DIV_RPM: begin
            if (div_rsp.done) begin
               reading_in = clamp_rpm;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            upd_in = 1'b1;
            neg_in = reading_ff < cur_speed_ff;
            dmag_in = neg_in ? (cur_speed_ff - reading_ff) : (reading_ff - cur_speed_ff);
            if (reading_ff < thr) begin
               new_in   = '0;
               state_in = ST_DONE;
            end else if (!cur_seen_ff || (dt_ff > 32'(gap_ff))) begin
               new_in   = reading_ff;
               state_in = ST_DONE;
            end else if (reading_ff == cur_speed_ff) begin
               new_in   = cur_speed_ff;
               state_in = ST_DONE;
            end else if (den == '0) begin
               // Time constant and elapsed time both zero: no lag coefficient.
               alpha_in = '0;
               state_in = ST_MUL_STEP;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_DW'(dt16) << ALPHA_FRAC_BITS;
               div_req.divisor  = den;
               state_in         = ST_DIV_ALPHA;
            end
         end
         ST_DIV_ALPHA: begin
            if (div_rsp.done) begin
               alpha_in = div_rsp.quotient[16:0];
               state_in = ST_MUL_STEP;
            end
         end
         ST_MUL_STEP: begin
            state_in = ST_MUL_SLEW;
         end
         ST_MUL_SLEW: begin
            // The step is at least one speed unit and never larger than the gap.
            step_in  = (shifted[16:0] == '0) ? 16'd1 : shifted[15:0];
            state_in = ST_LIM_START;
         end
         ST_LIM_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[DIV_DW-1:0];
            div_req.divisor  = MS_PER_SEC;
            state_in         = ST_DIV_LIM;
         end
         ST_DIV_LIM: begin
            if (div_rsp.done) begin
               if (32'(step_ff) > lim) begin
                  new_in = neg_ff ? (cur_speed_ff - lim16) : (cur_speed_ff + lim16);
               end else begin
                  new_in = neg_ff ? (cur_speed_ff - step_ff) : (cur_speed_ff + step_ff);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.rpm    = new_ff;
               rsp_data_in.status = res_status_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         upd_ff       <= 1'b0;
         seen_mem_ff  <= '0;
         for (int i = 0; i < FAN_COUNT; i++) begin
            speed_mem_ff[i] <= '0;
            time_mem_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         upd_ff       <= upd_in;
         if (state_wr) begin
            speed_mem_ff[wr_idx] <= new_ff;
            time_mem_ff[wr_idx]  <= now_ff;
            seen_mem_ff[wr_idx]  <= 1'b1;
         end
      end
      fan_ff        <= fan_in;
      fan_ok_ff     <= fan_ok_in;
      now_ff        <= now_in;
      raw_ff        <= raw_in;
      ok_ff         <= ok_in;
      cur_speed_ff  <= cur_speed_in;
      cur_time_ff   <= cur_time_in;
      cur_seen_ff   <= cur_seen_in;
      dt_ff         <= dt_in;
      reading_ff    <= reading_in;
      neg_ff        <= neg_in;
      dmag_ff       <= dmag_in;
      alpha_ff      <= alpha_in;
      step_ff       <= step_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      prod_ff       <= prod_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // A taken request always moves the sequencer out of idle.
   `FRLSF_ASSERT_NEXT(a_take_leaves_idle, clock, reset, req_take, state_ff != ST_IDLE, "request taken but sequencer stayed idle")
   // The divider only finishes while the sequencer waits for it.
   `FRLSF_ASSERT_NOW(a_div_done_waited, clock, reset, div_rsp.done, state_ff == ST_DIV_RPM || state_ff == ST_DIV_ALPHA || state_ff == ST_DIV_LIM, "divider finished outside a wait state")
   // Fan state changes only with an update result for an existing fan.
   `FRLSF_ASSERT_NOW(a_write_is_update, clock, reset, state_wr, res_status_ff == STATUS_UPDATED && fan_ok_ff, "fan state written without an update")
   // A result never carries an undefined status code.
   `FRLSF_ASSERT_NOW(a_rsp_status_known, clock, reset, rsp_valid, rsp_data.status == STATUS_UPDATED || rsp_data.status == STATUS_HELD || rsp_data.status == STATUS_ERROR, "result status code undefined")

endmodule

// ===== tb/fan_speed_checker.sv =====
`timescale 1ns / 1ps
module fan_speed_checker
   import frlsf_pkg::*;
#(
   parameter int FANS      = 3,
   parameter int FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          mismatch_count,
   output int          awaiting
);

   logic [15:0] max_rpm_r, tau_r, slew_r, stop_r, steps_r, min_iv_r, gap_r;
   logic [7:0]  mult_r;

   logic [15:0] speed   [FANS];
   logic [31:0] stamp   [FANS];
   logic        sampled [FANS];

   rsp_type     expected_speeds [$];

   initial begin
      mismatch_count = 0;
      awaiting       = 0;
   end

   task automatic flag(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: MISMATCH %s", $time, msg);
   endtask

   // Applies one request to the per-fan state and returns the result it must produce.
   function automatic rsp_type predict_fan_speed(input req_type r);
      rsp_type         o;
      int              f;
      logic [31:0]     dt;
      longint unsigned dt64, reading, thr, den, alpha, mag, lim_u;
      longint          cur, delta, step, lim;
      f        = r.fan_index;
      o.rpm    = '0;
      o.status = STATUS_ERROR;
      if (f >= FANS)
         return o;
      dt    = r.now_ms - stamp[f];
      o.rpm = speed[f];
      if (sampled[f] && dt < min_iv_r) begin
         o.status = STATUS_HELD;
         return o;
      end
      if (!r.read_ok)
         return o;

      reading = r.raw_count;
      if (steps_r != 0)
         reading = reading * max_rpm_r / steps_r;
      else
         reading = reading * mult_r;
      if (reading > max_rpm_r)
         reading = max_rpm_r;
      thr = (stop_r > STOP_FLOOR) ? stop_r : STOP_FLOOR;

      if (reading < thr) begin
         speed[f] = '0;
      end else if (!sampled[f] || dt > gap_r) begin
         speed[f] = reading[15:0];
      end else begin
         cur   = speed[f];
         delta = longint'(reading) - cur;
         if (delta != 0) begin
            dt64  = dt;
            den   = tau_r + dt64;
            alpha = (den != 0) ? (dt64 << FRAC_BITS) / den : 0;
            mag   = (delta < 0) ? -delta : delta;
            mag   = mag * alpha;
            // Shrinking steps round toward minus infinity, like an arithmetic shift.
            if (delta >= 0)
               step = mag >> FRAC_BITS;
            else
               step = -longint'((mag + (64'd1 << FRAC_BITS) - 1) >> FRAC_BITS);
            if (step == 0)
               step = (delta > 0) ? 1 : -1;
            lim_u = slew_r * dt64 / MS_PER_SEC;
            lim   = (lim_u < 1) ? 1 : longint'(lim_u);
            if (step > lim)
               step = lim;
            else if (step < -lim)
               step = -lim;
            speed[f] = 16'(cur + step);
         end
      end
      stamp[f]   = r.now_ms;
      sampled[f] = 1'b1;
      o.rpm      = speed[f];
      o.status   = STATUS_UPDATED;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         max_rpm_r = RST_MAX_RPM;
         tau_r     = RST_TAU_MS;
         slew_r    = RST_SLEW;
         stop_r    = RST_STOP_THR;
         steps_r   = RST_STEP_COUNT;
         mult_r    = RST_MULTIPLIER;
         min_iv_r  = RST_MIN_INTERVAL;
         gap_r     = RST_RESET_GAP;
         for (int i = 0; i < FANS; i++) begin
            speed[i]   = '0;
            stamp[i]   = '0;
            sampled[i] = 1'b0;
         end
         expected_speeds.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_MAX_RPM:      max_rpm_r = pwdata[15:0];
               REG_TAU_MS:       tau_r     = pwdata[15:0];
               REG_SLEW:         slew_r    = pwdata[15:0];
               REG_STOP_THR:     stop_r    = pwdata[15:0];
               REG_STEP_COUNT:   steps_r   = pwdata[15:0];
               REG_MULTIPLIER:   mult_r    = pwdata[7:0];
               REG_MIN_INTERVAL: min_iv_r  = pwdata[15:0];
               REG_RESET_GAP:    gap_r     = pwdata[15:0];
               default: ;
            endcase
         end
         // A result can only belong to an earlier request, so retire before queuing.
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               flag($sformatf("result with no request waiting: rpm %0d status %0d",
                              rsp_data.rpm, rsp_data.status));
            end else begin
               want = expected_speeds.pop_front();
               if (rsp_data.rpm != want.rpm)
                  flag($sformatf("rpm expected %0d, got %0d", want.rpm, rsp_data.rpm));
               if (rsp_data.status != want.status)
                  flag($sformatf("status expected %0d, got %0d",
                                 want.status, rsp_data.status));
            end
         end
         if (req_valid && !req_stall)
            expected_speeds.push_back(predict_fan_speed(req_data));
      end
      awaiting <= expected_speeds.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import frlsf_pkg::*;

   localparam int FANS      = 3;
   localparam int FRAC_BITS = 12;

   // Every block input starts at a known value; after time zero all but the clock
   // change only by nonblocking assignments at rising edges.
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [4:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          awaiting;

   // Percent chance per cycle that the sender holds back or the receiver stalls.
   int          send_idle_pct = 0;
   int          stall_pct     = 0;

   // What the registers currently hold, so that stimulus can aim at the
   // interesting time gaps and raw counts of the present setting.
   logic [15:0] shadow      [8];
   // Per fan: time of the last request that should have updated the fan,
   // whether it has had one, and the last raw count sent.
   logic [31:0] base_ms     [4];
   logic        fan_started [4];
   logic [15:0] last_raw    [4];

   fan_rpm_lag_slew_filter_core #(
      .FAN_COUNT       (FANS),
      .ALPHA_FRAC_BITS (FRAC_BITS)
   ) dut (.*);

   fan_speed_checker #(
      .FANS      (FANS),
      .FRAC_BITS (FRAC_BITS)
   ) speed_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random; the rate changes between phases.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Hard stop in case the block hangs. The slowest correct run is far shorter.
   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
   endtask

   // Offers one request and returns at the edge that accepts it. The valid is left
   // high, so the next request may follow at once without valid being lowered and
   // raised in the same time step.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Stops offering requests and waits until every request has its result.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (awaiting != 0);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic program_register(input logic [2:0] idx, input logic [15:0] value);
      shadow[idx] = value;
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_filter(input logic [15:0] max_rpm, tau, slew, stop, steps,
                                 input logic [7:0] mult,
                                 input logic [15:0] min_iv, gap);
      program_register(REG_MAX_RPM, max_rpm);
      program_register(REG_TAU_MS, tau);
      program_register(REG_SLEW, slew);
      program_register(REG_STOP_THR, stop);
      program_register(REG_STEP_COUNT, steps);
      program_register(REG_MULTIPLIER, {8'b0, mult});
      program_register(REG_MIN_INTERVAL, min_iv);
      program_register(REG_RESET_GAP, gap);
   endtask

   // Sends one reading and keeps the per-fan time base in step with the block:
   // the base moves only when the reading is expected to update the fan.
   task automatic issue(input logic [1:0] fan, input logic [31:0] now,
                        input logic [15:0] raw, input logic ok);
      req_type     item;
      logic [31:0] since;
      item.fan_index = fan;
      item.now_ms    = now;
      item.raw_count = raw;
      item.read_ok   = ok;
      send_request(item);
      since = now - base_ms[fan];
      if (fan < FANS && ok && (!fan_started[fan] || since >= shadow[REG_MIN_INTERVAL])) begin
         base_ms[fan]     = now;
         fan_started[fan] = 1'b1;
      end
      last_raw[fan] = raw;
   endtask

   // A random reading. Most land in the normal update window with raw counts that
   // the present scaling maps into range, so the lag and slew paths see long runs;
   // the rest hit the hold window, the window edges, wild times and bad reads.
   task automatic random_reading();
      int          pick;
      int unsigned hi;
      logic [1:0]  fan;
      logic [31:0] dt;
      logic [15:0] raw, mn, gp;
      logic        ok;
      fan  = ($urandom_range(99) < 3) ? 2'd3 : 2'($urandom_range(FANS - 1));
      ok   = ($urandom_range(99) >= 8);
      mn   = shadow[REG_MIN_INTERVAL];
      gp   = shadow[REG_RESET_GAP];
      pick = $urandom_range(99);
      if (pick < 10)
         dt = (mn == 0) ? 32'd0 : $urandom_range(mn - 1);
      else if (pick < 14)
         dt = mn;
      else if (pick < 18)
         dt = gp;
      else if (pick < 22)
         dt = gp + 32'd1;
      else if (pick < 26)
         dt = $urandom;
      else if (mn <= gp)
         dt = $urandom_range(gp, mn);
      else
         dt = $urandom_range(mn + 1000, mn);

      pick = $urandom_range(99);
      if (pick < 25) begin
         raw = $urandom_range(16'hFFFF);
      end else if (pick < 40) begin
         raw = $urandom_range(31);
      end else if (pick < 55) begin
         raw = last_raw[fan];
      end else if (pick < 62) begin
         raw = last_raw[fan] + 16'd1;
      end else if (shadow[REG_STEP_COUNT] != 0) begin
         raw = $urandom_range(shadow[REG_STEP_COUNT]);
      end else if (shadow[REG_MULTIPLIER] != 0) begin
         hi = shadow[REG_MAX_RPM] / shadow[REG_MULTIPLIER] + 1;
         if (hi > 16'hFFFF)
            hi = 16'hFFFF;
         raw = $urandom_range(hi);
      end else begin
         raw = $urandom_range(16'hFFFF);
      end
      issue(fan, base_ms[fan] + dt, raw, ok);
   endtask

   initial begin
      shadow[REG_MAX_RPM]      = RST_MAX_RPM;
      shadow[REG_TAU_MS]       = RST_TAU_MS;
      shadow[REG_SLEW]         = RST_SLEW;
      shadow[REG_STOP_THR]     = RST_STOP_THR;
      shadow[REG_STEP_COUNT]   = RST_STEP_COUNT;
      shadow[REG_MULTIPLIER]   = {8'b0, RST_MULTIPLIER};
      shadow[REG_MIN_INTERVAL] = RST_MIN_INTERVAL;
      shadow[REG_RESET_GAP]    = RST_RESET_GAP;
      for (int i = 0; i < 4; i++) begin
         base_ms[i]     = '0;
         fan_started[i] = 1'b0;
         last_raw[i]    = '0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed readings with the reset settings. The comments give the filter
      // value the block should land on.
      set_idling(37, 75);
      issue(2'd3, 32'd0, 16'hFFFF, 1'b1);        // fan that does not exist
      issue(2'd3, 32'hFFFF_FFFF, 16'd0, 1'b0);   // same, with a failed read
      issue(2'd0, 32'd0, 16'd3000, 1'b1);        // first sample snaps to 3000
      issue(2'd0, 32'd50, 16'd3000, 1'b0);       // hold wins over the read error
      issue(2'd0, 32'd99, 16'd3000, 1'b1);       // one short of the hold window
      issue(2'd0, 32'd100, 16'd4000, 1'b1);      // lag step up by 90
      issue(2'd0, 32'd200, 16'd4000, 1'b0);      // read error keeps the state
      issue(2'd0, 32'd300, 16'd0, 1'b1);         // below the stop threshold
      issue(2'd0, 32'd400, 16'hFFFF, 1'b1);      // clamped reading, slew limited to 125
      issue(2'd0, 32'd500, 16'd60, 1'b1);        // falling step rounds down to -6
      issue(2'd0, 32'd600, 16'd119, 1'b1);       // reading equals the filter value
      issue(2'd0, 32'd5601, 16'd2000, 1'b1);     // gap just past the limit snaps
      issue(2'd0, 32'd10601, 16'd3000, 1'b1);    // gap exactly at the limit filters
      issue(2'd1, 32'hFFFF_FF00, 16'd1000, 1'b1);
      issue(2'd1, 32'h0000_0050, 16'd1001, 1'b1); // time wraps; smallest step of one
      issue(2'd1, 32'h0000_0100, 16'd999, 1'b1);  // small fall rounds to -1
      issue(2'd2, 32'd1000, 16'd3000, 1'b0);     // failed read before any sample
      issue(2'd2, 32'd2000, 16'd49, 1'b1);       // first sample below the threshold
      issue(2'd2, 32'd2100, 16'd50, 1'b1);       // reading right at the threshold

      // Step-count scaling with a zero time constant and no hold window. Readings
      // at one instant make the coefficient zero and raise the slew limit to one, so every
      // move is a single RPM. A zero stop threshold falls back to the floor of 10.
      drain();
      program_filter(16'd900, 16'd0, RST_SLEW, 16'd0, 16'd100, 8'd1, 16'd0, RST_RESET_GAP);
      issue(2'd0, 32'h0010_0000, 16'd50, 1'b1);  // long gap, snaps to 450
      issue(2'd0, 32'h0010_0000, 16'd60, 1'b1);  // up one
      issue(2'd0, 32'h0010_0000, 16'd40, 1'b1);  // down one
      issue(2'd0, 32'h0010_0000, 16'd1, 1'b1);   // 9 RPM is under the floor
      issue(2'd0, 32'h0010_0000, 16'd2, 1'b1);   // 18 RPM starts from zero
      issue(2'd0, 32'h0010_0000, 16'd200, 1'b1); // reading clamped to the maximum
      issue(2'd1, 32'h0010_0000, 16'd101, 1'b1);

      // Random phases, each under its own setting, with the extremes among them.
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: program_filter(RST_MAX_RPM, RST_TAU_MS, RST_SLEW, RST_STOP_THR,
                              RST_STEP_COUNT, RST_MULTIPLIER, RST_MIN_INTERVAL,
                              RST_RESET_GAP);
            1: program_filter(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd0, 8'hFF,
                              16'd0, 16'hFFFF);
            2: program_filter(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 8'd0,
                              16'd0, 16'd0);
            3: program_filter(16'd1, 16'd1, 16'd1, 16'd10, 16'hFFFF, 8'hFF,
                              16'hFFFF, 16'hFFFF);
            4: program_filter(16'd12000, 16'd400, 16'd30000, 16'd20, 16'd0, 8'd7,
                              16'd20, 16'd2000);
            default:
               program_filter($urandom_range(20000, 500), $urandom_range(3000, 1),
                              $urandom_range(20000), $urandom_range(200),
                              $urandom_range(1) ? $urandom_range(4000, 1) : 0,
                              $urandom_range(255), $urandom_range(300),
                              $urandom_range(20000, 300));
         endcase
         // Busy receiver first, then busy sender, then both at full speed.
         if (ph < 3)
            set_idling(37, 75);
         else if (ph < 5)
            set_idling(75, 37);
         else
            set_idling(0, 0);
         for (int n = 0; n < 160; n++) begin
            // Now and then the sender waits for the block to empty completely.
            if ($urandom_range(99) == 0)
               drain();
            random_reading();
         end
      end

      drain();
      set_idling(0, 0);
      // Leave room for any stray result to show up before the verdict.
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && awaiting == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
